/* sv/kcl_pkg.sv */
package kcl_pkg;

  // Code geometry
  localparam int CODE_LENGTH = 5;
  localparam int DIGIT_W     = 3;
  localparam int CODE_W      = 15;
  localparam int POS_W       = $clog2(CODE_LENGTH + 1);
  localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam int LED_W       = 5;

  // Counter widths
  localparam int IDLE_W      = 8;
  localparam int BLINK_W     = 10;

  localparam logic [POS_W-1:0]   CODE_LEN_P    = POS_W'(CODE_LENGTH);
  localparam logic [BLINK_W-1:0] BLINK_MAX     = '1;
  localparam logic [DIGIT_W-1:0] RELOCK_BUTTON = DIGIT_W'(3);

  // Request kinds
  localparam logic [1:0] REQ_BUTTON = 2'd0;
  localparam logic [1:0] REQ_BLINK  = 2'd1;
  localparam logic [1:0] REQ_IDLE   = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_CODE_WORD    = 2'd0;
  localparam logic [1:0] REG_TIMEOUT      = 2'd1;
  localparam logic [1:0] REG_BLINK_ON     = 2'd2;
  localparam logic [1:0] REG_BLINK_PERIOD = 2'd3;

  // Register reset values
  localparam logic [CODE_W-1:0]  CODE_WORD_RST    = CODE_W'(872);
  localparam logic [IDLE_W-1:0]  TIMEOUT_RST      = IDLE_W'(4);
  localparam logic [BLINK_W-1:0] BLINK_ON_RST     = BLINK_W'(200);
  localparam logic [BLINK_W-1:0] BLINK_PERIOD_RST = BLINK_W'(800);

  typedef struct packed {
    logic [CODE_W-1:0]  code_word;
    logic [IDLE_W-1:0]  timeout_ticks;
    logic [BLINK_W-1:0] blink_on_ticks;
    logic [BLINK_W-1:0] blink_period_ticks;
  } kcl_cfg_t;

  typedef struct packed {
    logic [LED_W-1:0] progress_leds;
    logic             door_lamp;
    logic             unlocked;
    logic [POS_W-1:0] digits_entered;
  } kcl_result_t;

endpackage

/* sv/kcl_core.sv */
module kcl_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic [1:0]           req_type_i,
  input  logic [2:0]           button_index_i,
  input  kcl_pkg::kcl_cfg_t    cfg_i,
  output kcl_pkg::kcl_result_t result_o
);
  import kcl_pkg::*;

  logic                 mode_q, mode_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [BLINK_W-1:0]   blink_q, blink_d;
  logic [IDLE_W-1:0]    idle_q, idle_d;
  logic                 lamp_q, lamp_d;
  logic [DIGIT_W-1:0]   digits_q [CODE_LENGTH];
  logic                 digit_wr;
  logic                 code_match;
  logic [DIGIT_W-1:0]   cur_digit;

  // Store a digit on a press in entry mode while the code is incomplete
  assign digit_wr = !mode_q && (req_type_i == REQ_BUTTON) && (pos_q < CODE_LEN_P);

  // Compare the stored code, including the digit arriving now, with the key
  always_comb begin
    code_match = 1'b1;
    cur_digit  = '0;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      cur_digit = (digit_wr && (pos_q == POS_W'(i))) ? button_index_i : digits_q[i];
      if (cur_digit != cfg_i.code_word[DIGIT_W*i +: DIGIT_W]) begin
        code_match = 1'b0;
      end
    end
  end

  // Next state for one transfer
  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    blink_d = blink_q;
    idle_d  = idle_q;
    lamp_d  = lamp_q;

    // advance the tick counters, both saturating
    case (req_type_i)
      REQ_BLINK: begin
        if (blink_q != BLINK_MAX) begin
          blink_d = blink_q + BLINK_W'(1);
        end
      end
      REQ_IDLE: begin
        if (idle_q < cfg_i.timeout_ticks) begin
          idle_d = idle_q + IDLE_W'(1);
        end
      end
      default: ;
    endcase

    if (!mode_q) begin
      if (digit_wr) begin
        pos_d = pos_q + POS_W'(1);
      end
      if (pos_d >= CODE_LEN_P) begin
        if (code_match) begin
          mode_d = 1'b1;
        end else begin
          mode_d  = 1'b0;
          pos_d   = '0;
          blink_d = '0;
          idle_d  = '0;
          lamp_d  = 1'b0;
        end
      end
      if (idle_d >= cfg_i.timeout_ticks) begin
        mode_d  = 1'b0;
        pos_d   = '0;
        blink_d = '0;
        idle_d  = '0;
        lamp_d  = 1'b0;
      end
    end else if ((req_type_i == REQ_BUTTON) && (button_index_i == RELOCK_BUTTON)) begin
      mode_d  = 1'b0;
      pos_d   = '0;
      blink_d = '0;
      idle_d  = '0;
      lamp_d  = 1'b0;
    end

    // blink the lamp while unlocked
    if (mode_d) begin
      if (blink_d >= cfg_i.blink_period_ticks) begin
        blink_d = '0;
      end
      lamp_d = (blink_d <= cfg_i.blink_on_ticks);
    end
  end

  // Result fields
  always_comb begin
    for (int k = 0; k < LED_W; k++) begin
      result_o.progress_leds[k] = (pos_d > POS_W'(k));
    end
    result_o.door_lamp      = lamp_d;
    result_o.unlocked       = mode_d;
    result_o.digits_entered = pos_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      pos_q   <= '0;
      blink_q <= '0;
      idle_q  <= '0;
      lamp_q  <= 1'b0;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      blink_q <= blink_d;
      idle_q  <= idle_d;
      lamp_q  <= lamp_d;
    end
  end

  // Digit store
  always_ff @(posedge clk_i) begin
    if (advance_i && digit_wr) begin
      digits_q[pos_q[IDX_W-1:0]] <= button_index_i;
    end
  end

endmodule

/* sv/keypad_code_lock_top.sv */
// Keypad code lock.
// Input stream (s_axis): one transfer per event; tuser carries the request
// kind (button press, blink tick, idle tick), tdata the button index.
// Output stream (m_axis): exactly one result per event with the progress
// LEDs, door lamp, unlocked flag and number of digits entered.
// Configuration (APB): code word, idle timeout, lamp on time and blink
// period at byte addresses 0, 4, 8 and 12; write only while no event is
// in flight.
// An event is first held in the input register and, once the output
// register is free, its result is registered into the output register.
// Throughput: one event per cycle while results are taken; the state
// update is a single pass of logic between the input and output registers.
// Reset returns to entry mode with counters and lamp cleared and the
// registers at their default values. When the receiver stalls the result
// is held and one further event can still be taken into the input register.
module keypad_code_lock_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // event stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] button_index, [7:3] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [4:0] progress_leds, [5] door_lamp,
                                      // [6] unlocked, [9:7] digits_entered,
                                      // [15:10] zero
);
  import kcl_pkg::*;

  kcl_cfg_t    cfg_q;
  kcl_result_t result;
  kcl_result_t out_q;
  logic        in_valid_q;
  logic [1:0]  in_req_q;
  logic [2:0]  in_button_q;
  logic        out_valid_q;
  logic        advance;
  logic        cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_word          <= CODE_WORD_RST;
      cfg_q.timeout_ticks      <= TIMEOUT_RST;
      cfg_q.blink_on_ticks     <= BLINK_ON_RST;
      cfg_q.blink_period_ticks <= BLINK_PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CODE_WORD:    cfg_q.code_word          <= pwdata[CODE_W-1:0];
        REG_TIMEOUT:      cfg_q.timeout_ticks      <= pwdata[IDLE_W-1:0];
        REG_BLINK_ON:     cfg_q.blink_on_ticks     <= pwdata[BLINK_W-1:0];
        REG_BLINK_PERIOD: cfg_q.blink_period_ticks <= pwdata[BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3:2])
      REG_CODE_WORD:    prdata = 32'(cfg_q.code_word);
      REG_TIMEOUT:      prdata = 32'(cfg_q.timeout_ticks);
      REG_BLINK_ON:     prdata = 32'(cfg_q.blink_on_ticks);
      REG_BLINK_PERIOD: prdata = 32'(cfg_q.blink_period_ticks);
      default:          prdata = '0;
    endcase
  end

  // Handshake: move an event on when the output register is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_q    <= s_axis_tuser;
      in_button_q <= s_axis_tdata[2:0];
    end
  end

  kcl_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .req_type_i     (in_req_q),
    .button_index_i (in_button_q),
    .cfg_i          (cfg_q),
    .result_o       (result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q.digits_entered, out_q.unlocked,
                          out_q.door_lamp, out_q.progress_leds};

  // Checks
  a_unlock_full_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.unlocked |-> out_q.digits_entered == CODE_LEN_P)
    else $error("unlocked with an incomplete code");

  a_entry_short_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.unlocked |-> out_q.digits_entered < CODE_LEN_P)
    else $error("entry mode with a full code");

  a_entry_lamp_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.unlocked |-> !out_q.door_lamp)
    else $error("door lamp lit in entry mode");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("event processed without a result");

endmodule
